/* hw/rtl/pts_pkg.sv */
// pts_pkg: shared constants, codes and controller/datapath interface types
// for the priority task scheduler. No dependencies.
`default_nettype none
package pts_pkg;

	localparam int unsigned MAX_TASKS_DEF       = 32;
	localparam int unsigned PRIORITY_LEVELS_DEF = 32;
	localparam int unsigned DELAY_WIDTH_DEF     = 16;
	localparam logic [7:0]  SLICE_RESET         = 8'd10;

	// operation codes
	localparam logic [2:0] OPC_TICK    = 3'd0;
	localparam logic [2:0] OPC_CREATE  = 3'd1;
	localparam logic [2:0] OPC_START   = 3'd2;
	localparam logic [2:0] OPC_DELAY   = 3'd3;
	localparam logic [2:0] OPC_BLOCK   = 3'd4;
	localparam logic [2:0] OPC_WAKE    = 3'd5;
	localparam logic [2:0] OPC_SUSPEND = 3'd6;
	localparam logic [2:0] OPC_RESUME  = 3'd7;

	// task status codes
	localparam logic [2:0] ST_FREE      = 3'd0;
	localparam logic [2:0] ST_READY     = 3'd1;
	localparam logic [2:0] ST_RUNNING   = 3'd2;
	localparam logic [2:0] ST_BLOCKED   = 3'd3;
	localparam logic [2:0] ST_DELAYED   = 3'd4;
	localparam logic [2:0] ST_SUSPENDED = 3'd5;

	// datapath micro-operations
	typedef logic [3:0] uop_t;
	localparam uop_t UOP_NONE   = 4'd0;
	localparam uop_t UOP_LATCH  = 4'd1;
	localparam uop_t UOP_CHECK  = 4'd2;
	localparam uop_t UOP_CREATE = 4'd3;
	localparam uop_t UOP_RREM   = 4'd4;
	localparam uop_t UOP_RHEAD  = 4'd5;
	localparam uop_t UOP_RTAIL  = 4'd6;
	localparam uop_t UOP_WREM   = 4'd7;
	localparam uop_t UOP_WPUSH  = 4'd8;
	localparam uop_t UOP_START  = 4'd9;
	localparam uop_t UOP_WFIRST = 4'd10;
	localparam uop_t UOP_WSTEP  = 4'd11;
	localparam uop_t UOP_WWAKE  = 4'd12;
	localparam uop_t UOP_SCHED  = 4'd13;
	localparam uop_t UOP_SLICE  = 4'd14;
	localparam uop_t UOP_SETDLY = 4'd15;

	// which slot a micro-operation works on
	typedef logic [1:0] tsel_t;
	localparam tsel_t TS_ID   = 2'd0;
	localparam tsel_t TS_CUR  = 2'd1;
	localparam tsel_t TS_NODE = 2'd2;

	typedef struct packed {
		uop_t       uop;
		tsel_t      tsel;
		logic       set_st;
		logic [2:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       ok;
		logic       slice_act;
		logic       expire;
		logic       walk_end;
		logic       walk_zero;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/pts_ctrl.sv */
// pts_ctrl: sequencing state machine of the scheduler; issues micro-operations
// to pts_dpath and reads back its status. Depends on pts_pkg.
`default_nettype none
module pts_ctrl import pts_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          done
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CHECK  = 5'd1;
	localparam logic [4:0] S_TICK   = 5'd2;
	localparam logic [4:0] S_TREM   = 5'd3;
	localparam logic [4:0] S_TTAIL  = 5'd4;
	localparam logic [4:0] S_WFIRST = 5'd5;
	localparam logic [4:0] S_WSTEP  = 5'd6;
	localparam logic [4:0] S_WREM   = 5'd7;
	localparam logic [4:0] S_WWAKE  = 5'd8;
	localparam logic [4:0] S_CRE    = 5'd9;
	localparam logic [4:0] S_CPUSH  = 5'd10;
	localparam logic [4:0] S_START  = 5'd11;
	localparam logic [4:0] S_DLY    = 5'd12;
	localparam logic [4:0] S_DREM   = 5'd13;
	localparam logic [4:0] S_DPUSH  = 5'd14;
	localparam logic [4:0] S_REM    = 5'd15;
	localparam logic [4:0] S_WAKE   = 5'd16;
	localparam logic [4:0] S_SCHED  = 5'd17;
	localparam logic [4:0] S_DONE   = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '{uop: UOP_NONE, tsel: TS_ID, set_st: 1'b0, st: ST_FREE};
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.uop = UOP_LATCH;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.uop = UOP_CHECK;
				if (!stat.ok) begin
					state_d = S_DONE;
				end else begin
					case (stat.op)
						OPC_TICK:   state_d = S_TICK;
						OPC_CREATE: state_d = S_CRE;
						OPC_START:  state_d = S_START;
						OPC_DELAY:  state_d = S_DLY;
						OPC_BLOCK, OPC_SUSPEND: state_d = S_REM;
						default:    state_d = S_WAKE;
					endcase
				end
			end
			S_TICK: begin
				if (stat.slice_act) begin
					cmd.uop  = UOP_SLICE;
					cmd.tsel = TS_CUR;
					state_d  = stat.expire ? S_TREM : S_WFIRST;
				end else begin
					state_d = S_WFIRST;
				end
			end
			S_TREM: begin
				cmd = '{uop: UOP_RREM, tsel: TS_CUR, set_st: 1'b1, st: ST_READY};
				state_d = S_TTAIL;
			end
			S_TTAIL: begin
				cmd.uop  = UOP_RTAIL;
				cmd.tsel = TS_CUR;
				state_d  = S_WFIRST;
			end
			S_WFIRST: begin
				cmd.uop = UOP_WFIRST;
				state_d = S_WSTEP;
			end
			S_WSTEP: begin
				if (stat.walk_end) begin
					state_d = S_SCHED;
				end else begin
					cmd.uop  = UOP_WSTEP;
					cmd.tsel = TS_NODE;
					if (stat.walk_zero) state_d = S_WREM;
				end
			end
			S_WREM: begin
				cmd.uop  = UOP_WREM;
				cmd.tsel = TS_NODE;
				state_d  = S_WWAKE;
			end
			S_WWAKE: begin
				cmd = '{uop: UOP_WWAKE, tsel: TS_NODE, set_st: 1'b1, st: ST_READY};
				state_d = S_WSTEP;
			end
			S_CRE: begin
				cmd = '{uop: UOP_CREATE, tsel: TS_ID, set_st: 1'b1, st: ST_READY};
				state_d = S_CPUSH;
			end
			S_CPUSH: begin
				cmd.uop = UOP_RHEAD;
				state_d = S_DONE;
			end
			S_START: begin
				cmd.uop = UOP_START;
				state_d = S_SCHED;
			end
			S_DLY: begin
				cmd = '{uop: UOP_SETDLY, tsel: TS_CUR, set_st: 1'b1, st: ST_DELAYED};
				state_d = S_DREM;
			end
			S_DREM: begin
				cmd.uop  = UOP_RREM;
				cmd.tsel = TS_CUR;
				state_d  = S_DPUSH;
			end
			S_DPUSH: begin
				cmd.uop  = UOP_WPUSH;
				cmd.tsel = TS_CUR;
				state_d  = S_SCHED;
			end
			S_REM: begin
				cmd.uop    = UOP_RREM;
				cmd.set_st = 1'b1;
				cmd.st     = (stat.op == OPC_BLOCK) ? ST_BLOCKED : ST_SUSPENDED;
				state_d    = S_SCHED;
			end
			S_WAKE: begin
				cmd = '{uop: UOP_RHEAD, tsel: TS_ID, set_st: 1'b1, st: ST_READY};
				state_d = S_SCHED;
			end
			S_SCHED: begin
				cmd.uop = UOP_SCHED;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

/* hw/rtl/pts_dpath.sv */
// pts_dpath: task table, ready lists, delay list and scheduler state; carries
// out one micro-operation per cycle as commanded by pts_ctrl. Depends on pts_pkg.
`default_nettype none
module pts_dpath import pts_pkg::*; #(
	parameter int unsigned MAX_TASKS       = MAX_TASKS_DEF,
	parameter int unsigned PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
	parameter int unsigned DELAY_WIDTH     = DELAY_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	input  wire logic [2:0]  opcode,
	input  wire logic [4:0]  task_id,
	input  wire logic [4:0]  task_priority,
	input  wire logic [15:0] wait_ticks,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	output logic [4:0]       running_task,
	output logic             running_valid,
	output logic             switched,
	output logic             accepted
);

	localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
	localparam int unsigned CW = $clog2(MAX_TASKS + 1);
	localparam logic [TW:0] NIL = {1'b1, {TW{1'b0}}};

	// links carry an end-of-list flag in the top bit
	logic [LW-1:0]          prio_q  [MAX_TASKS];
	logic [2:0]             status_q[MAX_TASKS];
	logic [DELAY_WIDTH-1:0] dly_q   [MAX_TASKS];
	logic [7:0]             slc_q   [MAX_TASKS];
	logic [TW:0]            lf_q    [MAX_TASKS];
	logic [TW:0]            lb_q    [MAX_TASKS];
	logic [TW-1:0]          head_q  [PRIORITY_LEVELS];
	logic [TW-1:0]          tail_q  [PRIORITY_LEVELS];
	logic [PRIORITY_LEVELS-1:0] mask_q;
	logic [TW:0]            wh_q;
	logic [TW-1:0]          cur_q;
	logic                   started_q;
	logic                   run_valid_q;
	logic [7:0]             tst_q;
	logic                   ok_q;
	logic                   sw_q;
	logic [TW:0]            node_q;
	logic [TW:0]            next_q;
	logic [CW-1:0]          cnt_q;
	logic [2:0]             op_q;
	logic [4:0]             id_q;
	logic [4:0]             pr_q;
	logic [DELAY_WIDTH-1:0] ticks_q;

	logic                   id_ok;
	logic [TW-1:0]          id_idx;
	logic [2:0]             st_id;
	logic [2:0]             st_cur;
	logic                   ok_c;
	logic [TW-1:0]          tgt;
	logic [LW-1:0]          t_prio;
	logic [TW:0]            t_prev;
	logic [TW:0]            t_next;
	logic [TW-1:0]          hd;
	logic [TW-1:0]          tl;
	logic                   mk;
	logic                   head_is_t;
	logic                   tail_is_t;
	logic [TW:0]            new_head;
	logic [TW:0]            new_tail;
	logic [TW-1:0]          nd;
	logic [DELAY_WIDTH-1:0] dec;
	logic                   found;
	logic [LW-1:0]          lvl;
	logic [TW-1:0]          pick;
	logic                   wh_is_t;

	always_comb begin
		id_ok  = (32'(id_q) < MAX_TASKS);
		id_idx = TW'(id_q);
		st_id  = id_ok ? status_q[id_idx] : ST_FREE;
		st_cur = status_q[cur_q];
		case (op_q)
			OPC_TICK:    ok_c = started_q;
			OPC_CREATE:  ok_c = id_ok && (st_id == ST_FREE) && (32'(pr_q) < PRIORITY_LEVELS);
			OPC_START:   ok_c = !started_q && (mask_q != '0);
			OPC_DELAY:   ok_c = started_q && run_valid_q && (ticks_q != '0) &&
			                    (st_cur == ST_RUNNING);
			OPC_BLOCK:   ok_c = id_ok && (st_id == ST_RUNNING);
			OPC_WAKE:    ok_c = id_ok && (st_id == ST_BLOCKED);
			OPC_SUSPEND: ok_c = id_ok && ((st_id == ST_READY) || (st_id == ST_RUNNING));
			OPC_RESUME:  ok_c = id_ok && (st_id == ST_SUSPENDED);
			default:     ok_c = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.tsel)
			TS_CUR:  tgt = cur_q;
			TS_NODE: tgt = node_q[TW-1:0];
			default: tgt = id_idx;
		endcase
		t_prio    = prio_q[tgt];
		t_prev    = lb_q[tgt];
		t_next    = lf_q[tgt];
		hd        = head_q[t_prio];
		tl        = tail_q[t_prio];
		mk        = mask_q[t_prio];
		head_is_t = (hd == tgt);
		tail_is_t = (tl == tgt);
		new_head  = head_is_t ? t_next : {1'b0, hd};
		new_tail  = tail_is_t ? t_prev : {1'b0, tl};
		wh_is_t   = (wh_q == {1'b0, tgt});
		nd        = node_q[TW-1:0];
		dec       = dly_q[nd] - 1'b1;
	end

	// most urgent non-empty level
	always_comb begin
		found = 1'b0;
		lvl   = '0;
		for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				found = 1'b1;
				lvl   = LW'(i);
			end
		end
		pick = head_q[lvl];
	end

	always_comb begin
		stat.op        = op_q;
		stat.ok        = ok_c;
		stat.slice_act = run_valid_q && (st_cur == ST_RUNNING);
		stat.expire    = (slc_q[cur_q] <= 8'd1);
		stat.walk_end  = node_q[TW] || (cnt_q == CW'(MAX_TASKS));
		stat.walk_zero = (dec == '0);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) status_q[i] <= ST_FREE;
			mask_q      <= '0;
			wh_q        <= NIL;
			cur_q       <= '0;
			started_q   <= 1'b0;
			run_valid_q <= 1'b0;
			tst_q       <= SLICE_RESET;
			ok_q        <= 1'b0;
			sw_q        <= 1'b0;
			node_q      <= NIL;
			next_q      <= NIL;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) tst_q <= cfg_wdata;
			case (cmd.uop)
				UOP_LATCH: begin
					ok_q <= 1'b0;
					sw_q <= 1'b0;
				end
				UOP_CHECK: ok_q <= ok_c;
				UOP_RREM: begin
					if (new_head[TW]) mask_q[t_prio] <= 1'b0;
				end
				UOP_RHEAD, UOP_RTAIL: mask_q[t_prio] <= 1'b1;
				UOP_WREM: begin
					if (wh_is_t) wh_q <= t_next;
				end
				UOP_WPUSH: wh_q <= {1'b0, tgt};
				UOP_START: started_q <= 1'b1;
				UOP_WFIRST: begin
					node_q <= wh_q;
					cnt_q  <= '0;
				end
				UOP_WSTEP: begin
					if (dec != '0) begin
						node_q <= t_next;
						cnt_q  <= cnt_q + 1'b1;
					end else begin
						next_q <= t_next;
					end
				end
				UOP_WWAKE: begin
					mask_q[t_prio] <= 1'b1;
					node_q <= next_q;
					cnt_q  <= cnt_q + 1'b1;
				end
				UOP_SCHED: begin
					if (started_q) begin
						if (!found) begin
							run_valid_q <= 1'b0;
							sw_q        <= 1'b0;
						end else begin
							sw_q <= !run_valid_q || (pick != cur_q);
							if ((pick != cur_q) && (st_cur == ST_RUNNING))
								status_q[cur_q] <= ST_READY;
							status_q[pick] <= ST_RUNNING;
							cur_q          <= pick;
							run_valid_q    <= 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (cmd.set_st) status_q[tgt] <= cmd.st;
		end
	end

	// table and link storage
	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_LATCH: begin
				op_q    <= opcode;
				id_q    <= task_id;
				pr_q    <= task_priority;
				ticks_q <= DELAY_WIDTH'(wait_ticks);
			end
			UOP_CREATE: begin
				prio_q[tgt] <= LW'(pr_q);
				dly_q[tgt]  <= '0;
				slc_q[tgt]  <= tst_q;
			end
			UOP_SLICE: begin
				slc_q[tgt] <= (slc_q[tgt] <= 8'd1) ? tst_q : slc_q[tgt] - 8'd1;
			end
			UOP_SETDLY: dly_q[tgt] <= ticks_q;
			UOP_WSTEP: dly_q[nd] <= dec;
			UOP_RREM: begin
				if (!head_is_t && !t_prev[TW]) lf_q[t_prev[TW-1:0]] <= t_next;
				if (!tail_is_t && !t_next[TW]) lb_q[t_next[TW-1:0]] <= t_prev;
				if (!new_head[TW]) begin
					head_q[t_prio] <= new_head[TW-1:0];
					tail_q[t_prio] <= new_tail[TW-1:0];
				end
			end
			UOP_RHEAD, UOP_WWAKE: begin
				lb_q[tgt] <= NIL;
				lf_q[tgt] <= mk ? {1'b0, hd} : NIL;
				if (mk) lb_q[hd] <= {1'b0, tgt};
				else tail_q[t_prio] <= tgt;
				head_q[t_prio] <= tgt;
			end
			UOP_RTAIL: begin
				lf_q[tgt] <= NIL;
				lb_q[tgt] <= mk ? {1'b0, tl} : NIL;
				if (mk) lf_q[tl] <= {1'b0, tgt};
				else head_q[t_prio] <= tgt;
				tail_q[t_prio] <= tgt;
			end
			UOP_WREM: begin
				if (!wh_is_t && !t_prev[TW]) lf_q[t_prev[TW-1:0]] <= t_next;
				if (!t_next[TW]) lb_q[t_next[TW-1:0]] <= t_prev;
			end
			UOP_WPUSH: begin
				lb_q[tgt] <= NIL;
				lf_q[tgt] <= wh_q;
				if (!wh_q[TW]) lb_q[wh_q[TW-1:0]] <= {1'b0, tgt};
			end
			default: ;
		endcase
	end

	assign running_valid = started_q && run_valid_q;
	assign running_task  = running_valid ? 5'(cur_q) : 5'd0;
	assign switched      = sw_q;
	assign accepted      = ok_q;

endmodule
`default_nettype wire

/* hw/rtl/priority_task_scheduler_core.sv */
// A transaction is checked; an ignored one goes to done, others update the lists,
// then schedule (create does not), then done. A tick counts down the runner's slice,
// requeues the runner at its tail when it runs out, and walks the delay list, waking
// expired tasks. Next transaction is accepted the cycle after done; receiver cannot stall.
// Async active-low reset: all slots free, nothing ready, not started, slice 10.
// Top level: instantiates pts_ctrl and pts_dpath; depends on pts_pkg.
`default_nettype none
module priority_task_scheduler_core import pts_pkg::*; #(
	parameter int unsigned MAX_TASKS       = MAX_TASKS_DEF,
	parameter int unsigned PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
	parameter int unsigned DELAY_WIDTH     = DELAY_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [4:0]  task_id,
	input  wire logic [4:0]  task_priority,
	input  wire logic [15:0] wait_ticks,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	output logic             done,
	output logic [4:0]       running_task,
	output logic             running_valid,
	output logic             switched,
	output logic             accepted
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pts_dpath #(
		.MAX_TASKS       (MAX_TASKS),
		.PRIORITY_LEVELS (PRIORITY_LEVELS),
		.DELAY_WIDTH     (DELAY_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (opcode),
		.task_id       (task_id),
		.task_priority (task_priority),
		.wait_ticks    (wait_ticks),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.running_task  (running_task),
		.running_valid (running_valid),
		.switched      (switched),
		.accepted      (accepted)
	);

endmodule
`default_nettype wire

/* hw/rtl/pts_checker.sv */
// pts_checker: port-level assertions for priority_task_scheduler_core,
// attached by the bind below. Depends on nothing else.
`default_nettype none
module pts_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [4:0] running_task,
	input wire logic       running_valid,
	input wire logic       switched,
	input wire logic       accepted
);

	// a result belongs to a transaction still in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted start not busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !running_valid) |-> (running_task == 5'd0 && !switched))
		else $error("result without runner is not clear");

	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && switched) |-> (accepted && running_valid))
		else $error("switch on ignored transaction");

endmodule

bind priority_task_scheduler_core pts_checker u_pts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.running_task  (running_task),
	.running_valid (running_valid),
	.switched      (switched),
	.accepted      (accepted)
);
`default_nettype wire

/* sim/priority_task_scheduler_core_tb.sv */
// priority_task_scheduler_core_tb: directed table plus constrained-by-hand random
// operations; results are compared with the table's typed results or with an
// in-bench scheduler prediction. Depends on pts_pkg and priority_task_scheduler_core.
`default_nettype none
module priority_task_scheduler_core_tb;
	import pts_pkg::*;

	localparam int NSLOT = 32;
	localparam int NIL = 32;
	localparam int SETTLE = 130;
	localparam int LIMIT = 1000000;
	localparam int NDIR = 24;

	typedef struct packed {
		logic [4:0] running_task;
		logic       running_valid;
		logic       switched;
		logic       accepted;
	} sched_res_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [4:0]  id;
		logic [4:0]  prio;
		logic [15:0] ticks;
		logic        typed;
		sched_res_t  res;
	} dir_row_t;

	logic        clk, arst_n, start, busy, done;
	logic [2:0]  opcode;
	logic [4:0]  task_id, task_priority;
	logic [15:0] wait_ticks;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic [4:0]  running_task;
	logic        running_valid, switched, accepted;

	priority_task_scheduler_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .task_id(task_id), .task_priority(task_priority),
		.wait_ticks(wait_ticks), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .running_task(running_task), .running_valid(running_valid),
		.switched(switched), .accepted(accepted)
	);

	// scheduler prediction state
	logic [7:0]  slice_len;
	logic [4:0]  t_prio [NSLOT];
	logic [2:0]  t_stat [NSLOT];
	logic [15:0] t_delay [NSLOT];
	logic [7:0]  t_slice [NSLOT];
	int          fwd [NSLOT], bwd [NSLOT], lvl_head [NSLOT], lvl_tail [NSLOT];
	logic [31:0] lvl_ready;
	int          wait_head, cur_slot;
	bit          started, runner_ok;

	sched_res_t pending_results [$];
	int         n_errors;
	int         cyc;

	dir_row_t dir_tab [NDIR] = '{
		'{OPC_TICK,    5'd0,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b0}},
		'{OPC_DELAY,   5'd0,  5'd0,  16'd5,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b0}},
		'{OPC_START,   5'd0,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b0}},
		'{OPC_WAKE,    5'd5,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b0}},
		'{OPC_CREATE,  5'd31, 5'd31, 16'hffff,  1'b1, '{5'd0, 1'b0, 1'b0, 1'b1}},
		'{OPC_CREATE,  5'd0,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b1}},
		'{OPC_CREATE,  5'd0,  5'd3,  16'd0,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b0}},
		'{OPC_SUSPEND, 5'd31, 5'd0,  16'd0,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b1}},
		'{OPC_RESUME,  5'd31, 5'd0,  16'd0,     1'b1, '{5'd0, 1'b0, 1'b0, 1'b1}},
		'{OPC_START,   5'd0,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b1, 1'b1, 1'b1}},
		'{OPC_START,   5'd0,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b1, 1'b0, 1'b0}},
		'{OPC_CREATE,  5'd7,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b1, 1'b0, 1'b1}},
		'{OPC_DELAY,   5'd0,  5'd0,  16'd0,     1'b1, '{5'd0, 1'b1, 1'b0, 1'b0}},
		'{OPC_TICK,    5'd0,  5'd0,  16'd0,     1'b0, '0},
		'{OPC_BLOCK,   5'd0,  5'd0,  16'd0,     1'b0, '0},
		'{OPC_BLOCK,   5'd31, 5'd0,  16'd0,     1'b0, '0},
		'{OPC_DELAY,   5'd0,  5'd0,  16'd65535, 1'b0, '0},
		'{OPC_WAKE,    5'd7,  5'd0,  16'd0,     1'b0, '0},
		'{OPC_WAKE,    5'd0,  5'd0,  16'd0,     1'b0, '0},
		'{OPC_CREATE,  5'd16, 5'd31, 16'd0,     1'b0, '0},
		'{OPC_DELAY,   5'd0,  5'd0,  16'd1,     1'b0, '0},
		'{OPC_TICK,    5'd0,  5'd0,  16'd0,     1'b0, '0},
		'{OPC_SUSPEND, 5'd31, 5'd0,  16'd0,     1'b0, '0},
		'{OPC_RESUME,  5'd3,  5'd0,  16'd0,     1'b0, '0}
	};

	function automatic void ready_unlink(int t);
		int p, pv, nx;
		p = t_prio[t];
		pv = bwd[t];
		nx = fwd[t];
		if (lvl_head[p] == t) lvl_head[p] = nx;
		else if (pv < NSLOT) fwd[pv] = nx;
		if (lvl_tail[p] == t) lvl_tail[p] = pv;
		else if (nx < NSLOT) bwd[nx] = pv;
		if (lvl_head[p] >= NSLOT) begin
			lvl_head[p] = NIL;
			lvl_tail[p] = NIL;
			lvl_ready[p] = 1'b0;
		end
	endfunction

	function automatic void ready_to_head(int t);
		int p, h;
		p = t_prio[t];
		h = lvl_head[p];
		bwd[t] = NIL;
		fwd[t] = h;
		if (h < NSLOT) bwd[h] = t;
		else lvl_tail[p] = t;
		lvl_head[p] = t;
		lvl_ready[p] = 1'b1;
	endfunction

	function automatic void ready_to_tail(int t);
		int p, tl;
		p = t_prio[t];
		tl = lvl_tail[p];
		fwd[t] = NIL;
		bwd[t] = tl;
		if (tl < NSLOT) fwd[tl] = t;
		else lvl_head[p] = t;
		lvl_tail[p] = t;
		lvl_ready[p] = 1'b1;
	endfunction

	function automatic void wait_unlink(int t);
		int pv, nx;
		pv = bwd[t];
		nx = fwd[t];
		if (wait_head == t) wait_head = nx;
		else if (pv < NSLOT) fwd[pv] = nx;
		if (nx < NSLOT) bwd[nx] = pv;
	endfunction

	function automatic bit pick_runner();
		int p, pick;
		bit sw;
		if (!started) return 1'b0;
		for (p = 0; p < NSLOT; p++)
			if (lvl_ready[p] && lvl_head[p] < NSLOT) break;
		if (p >= NSLOT) begin
			runner_ok = 1'b0;
			return 1'b0;
		end
		pick = lvl_head[p];
		sw = !runner_ok || pick != cur_slot;
		if (pick != cur_slot && t_stat[cur_slot] == ST_RUNNING) t_stat[cur_slot] = ST_READY;
		t_stat[pick] = ST_RUNNING;
		cur_slot = pick;
		runner_ok = 1'b1;
		return sw;
	endfunction

	function automatic bit tick_advance();
		int node, nx, n;
		if (runner_ok && t_stat[cur_slot] == ST_RUNNING) begin
			if (t_slice[cur_slot] <= 1) begin
				t_slice[cur_slot] = slice_len;
				ready_unlink(cur_slot);
				ready_to_tail(cur_slot);
				t_stat[cur_slot] = ST_READY;
			end else begin
				t_slice[cur_slot]--;
			end
		end
		node = wait_head;
		for (n = 0; n < NSLOT && node < NSLOT; n++) begin
			nx = fwd[node];
			t_delay[node] = t_delay[node] - 16'd1;
			if (t_delay[node] == 0) begin
				wait_unlink(node);
				ready_to_head(node);
				t_stat[node] = ST_READY;
			end
			node = nx;
		end
		return pick_runner();
	endfunction

	function automatic sched_res_t sched_step(logic [2:0] op, int id, logic [4:0] prio,
			logic [15:0] ticks);
		sched_res_t r;
		bit ok, sw;
		logic [2:0] st;
		ok = 1'b0;
		sw = 1'b0;
		st = t_stat[id];
		case (op)
			OPC_TICK: if (started) begin
				ok = 1'b1;
				sw = tick_advance();
			end
			OPC_CREATE: if (st == ST_FREE) begin
				t_prio[id] = prio;
				t_delay[id] = '0;
				t_slice[id] = slice_len;
				t_stat[id] = ST_READY;
				ready_to_head(id);
				ok = 1'b1;
			end
			OPC_START: if (!started && lvl_ready != 0) begin
				started = 1'b1;
				ok = 1'b1;
				sw = pick_runner();
			end
			OPC_DELAY: if (started && runner_ok && ticks != 0 &&
					t_stat[cur_slot] == ST_RUNNING) begin
				t_delay[cur_slot] = ticks;
				ready_unlink(cur_slot);
				bwd[cur_slot] = NIL;
				fwd[cur_slot] = wait_head;
				if (wait_head < NSLOT) bwd[wait_head] = cur_slot;
				wait_head = cur_slot;
				t_stat[cur_slot] = ST_DELAYED;
				ok = 1'b1;
				sw = pick_runner();
			end
			OPC_BLOCK: if (st == ST_RUNNING) begin
				ready_unlink(id);
				t_stat[id] = ST_BLOCKED;
				ok = 1'b1;
				sw = pick_runner();
			end
			OPC_WAKE, OPC_RESUME:
				if ((op == OPC_WAKE && st == ST_BLOCKED) ||
						(op == OPC_RESUME && st == ST_SUSPENDED)) begin
					t_stat[id] = ST_READY;
					ready_to_head(id);
					ok = 1'b1;
					sw = pick_runner();
				end
			default: if (st == ST_READY || st == ST_RUNNING) begin
				ready_unlink(id);
				t_stat[id] = ST_SUSPENDED;
				ok = 1'b1;
				sw = pick_runner();
			end
		endcase
		r.running_valid = started && runner_ok;
		r.running_task = r.running_valid ? 5'(cur_slot) : 5'd0;
		r.switched = sw;
		r.accepted = ok;
		return r;
	endfunction

	// random slot in the given status, or any slot when none is
	function automatic int slot_in_status(logic [2:0] st);
		int hits [$];
		for (int i = 0; i < NSLOT; i++)
			if (t_stat[i] == st) hits.push_back(i);
		if (hits.size() == 0) return $urandom_range(NSLOT - 1);
		return hits[$urandom_range(hits.size() - 1)];
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result checker: each done is checked against the oldest pending expected result
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: task %0d", running_task);
				n_errors++;
			end else begin
				sched_res_t e;
				e = pending_results.pop_front();
				if (running_task !== e.running_task) begin
					$error("running_task expected %0d actual %0d", e.running_task, running_task);
					n_errors++;
				end
				if (running_valid !== e.running_valid) begin
					$error("running_valid expected %0b actual %0b",
						e.running_valid, running_valid);
					n_errors++;
				end
				if (switched !== e.switched) begin
					$error("switched expected %0b actual %0b", e.switched, switched);
					n_errors++;
				end
				if (accepted !== e.accepted) begin
					$error("accepted expected %0b actual %0b", e.accepted, accepted);
					n_errors++;
				end
			end
		end
	end

	task automatic issue_op(logic [2:0] op, logic [4:0] id, logic [4:0] prio,
			logic [15:0] ticks, int idle_pct, bit typed, sched_res_t typed_res);
		sched_res_t r;
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		task_id <= id;
		task_priority <= prio;
		wait_ticks <= ticks;
		do @(posedge clk); while (busy);
		r = sched_step(op, id, prio, ticks);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain_and_settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_slice(logic [7:0] v);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		slice_len = v;
	endtask

	task automatic random_op(int idle_pct);
		logic [2:0] op;
		logic [4:0] id, prio;
		logic [15:0] ticks;
		int w;
		w = $urandom_range(99);
		if (w < 30) op = OPC_TICK;
		else if (w < 38) op = OPC_CREATE;
		else if (w < 50) op = OPC_DELAY;
		else if (w < 62) op = OPC_BLOCK;
		else if (w < 74) op = OPC_WAKE;
		else if (w < 84) op = OPC_SUSPEND;
		else if (w < 94) op = OPC_RESUME;
		else op = OPC_START;
		id = $urandom_range(31);
		if ($urandom_range(99) < 80) begin
			case (op)
				OPC_CREATE: id = slot_in_status(ST_FREE);
				OPC_BLOCK: id = slot_in_status(ST_RUNNING);
				OPC_WAKE: id = slot_in_status(ST_BLOCKED);
				OPC_SUSPEND: id = slot_in_status($urandom_range(1) ? ST_READY : ST_RUNNING);
				OPC_RESUME: id = slot_in_status(ST_SUSPENDED);
				default: ;
			endcase
		end
		prio = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
		w = $urandom_range(99);
		if (w < 3) ticks = 16'($urandom_range(65535));
		else if (w < 8) ticks = 16'd0;
		else if (w < 80) ticks = 16'($urandom_range(8, 1));
		else ticks = 16'($urandom_range(60, 9));
		issue_op(op, id, prio, ticks, idle_pct, 1'b0, '0);
	endtask

	initial begin
		int phase_idle [4] = '{37, 54, 0, 0};
		logic [7:0] phase_slice [4] = '{8'd1, 8'd255, 8'd0, 8'd3};
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OPC_TICK;
		task_id <= '0;
		task_priority <= '0;
		wait_ticks <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		slice_len = SLICE_RESET;
		for (int i = 0; i < NSLOT; i++) begin
			t_prio[i] = '0;
			t_stat[i] = ST_FREE;
			t_delay[i] = '0;
			t_slice[i] = '0;
			fwd[i] = NIL;
			bwd[i] = NIL;
			lvl_head[i] = NIL;
			lvl_tail[i] = NIL;
		end
		lvl_ready = '0;
		wait_head = NIL;
		cur_slot = 0;
		started = 1'b0;
		runner_ok = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			issue_op(dir_tab[i].op, dir_tab[i].id, dir_tab[i].prio, dir_tab[i].ticks, 0,
				dir_tab[i].typed, dir_tab[i].res);

		for (int ph = 0; ph < 4; ph++) begin
			write_slice(phase_slice[ph]);
			repeat (400) random_op(phase_idle[ph]);
		end

		drain_and_settle();
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
